/* sv/dgr_pkg.sv */
package dgr_pkg;

    localparam int ROW_W  = 16;
    localparam int VTX_W  = 4;
    localparam int CNT_W  = 5;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CONN  = 2'd1;
    localparam logic [1:0] OP_PRINT = 2'd2;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_REACH   = 3'd1;
    localparam logic [2:0] ST_NOREACH = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_ROW     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_PRINT,
        S_REPLY
    } dgr_state_t;

    typedef struct packed {
        logic       capture;
        logic       add_edge;
        logic       search_init;
        logic       step_fwd;
        logic       step_back;
        logic       print_init;
        logic       print_next;
        logic       emit;
        logic       emit_row;
        logic [2:0] status;
    } dgr_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       bad_vertex;
        logic       at_target;
        logic       has_cand;
        logic       at_source;
        logic       row_last;
        logic       out_free;
    } dgr_sts_t;

    function automatic logic [VTX_W-1:0] lowest_set(input logic [ROW_W-1:0] bits);
        logic [VTX_W-1:0] r;
        r = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                r = VTX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

/* sv/dgr_ctrl.sv */
module dgr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dgr_pkg::dgr_sts_t sts,
    output dgr_pkg::dgr_cmd_t cmd
);

    dgr_pkg::dgr_state_t state_reg, state_next;
    logic [2:0] reply_reg, reply_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dgr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reply_reg <= reply_next;
    end

    always_comb
    begin
        state_next = state_reg;
        reply_next = reply_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            dgr_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = dgr_pkg::S_DECODE;
                end
            end
            dgr_pkg::S_DECODE:
            begin
                case (sts.op)
                    dgr_pkg::OP_PRINT:
                    begin
                        cmd.print_init = 1'b1;
                        state_next     = dgr_pkg::S_PRINT;
                    end
                    dgr_pkg::OP_ADD:
                    begin
                        if (sts.bad_vertex)
                        begin
                            reply_next = dgr_pkg::ST_INVALID;
                        end
                        else
                        begin
                            cmd.add_edge = 1'b1;
                            reply_next   = dgr_pkg::ST_ADDED;
                        end
                        state_next = dgr_pkg::S_REPLY;
                    end
                    dgr_pkg::OP_CONN:
                    begin
                        if (sts.bad_vertex)
                        begin
                            reply_next = dgr_pkg::ST_INVALID;
                            state_next = dgr_pkg::S_REPLY;
                        end
                        else
                        begin
                            cmd.search_init = 1'b1;
                            state_next      = dgr_pkg::S_SEARCH;
                        end
                    end
                    default:
                    begin
                        reply_next = dgr_pkg::ST_INVALID;
                        state_next = dgr_pkg::S_REPLY;
                    end
                endcase
            end
            dgr_pkg::S_SEARCH:
            begin
                if (sts.at_target)
                begin
                    reply_next = dgr_pkg::ST_REACH;
                    state_next = dgr_pkg::S_REPLY;
                end
                else if (sts.has_cand)
                begin
                    cmd.step_fwd = 1'b1;
                end
                else if (sts.at_source)
                begin
                    reply_next = dgr_pkg::ST_NOREACH;
                    state_next = dgr_pkg::S_REPLY;
                end
                else
                begin
                    cmd.step_back = 1'b1;
                end
            end
            dgr_pkg::S_PRINT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_row   = 1'b1;
                    cmd.status     = dgr_pkg::ST_ROW;
                    cmd.print_next = 1'b1;
                    if (sts.row_last)
                    begin
                        state_next = dgr_pkg::S_IDLE;
                    end
                end
            end
            dgr_pkg::S_REPLY:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = reply_reg;
                    state_next = dgr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dgr_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result issued while output register is occupied");

    a_capture_decode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == dgr_pkg::S_DECODE)
        else $error("captured word not decoded");

    a_search_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_fwd || cmd.step_back) |-> !sts.at_target)
        else $error("search stepped past the target");
`endif

endmodule

/* sv/dgr_datapath.sv */
module dgr_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [dgr_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic [1:0]                  in_op,
    input  logic [dgr_pkg::VTX_W-1:0]   in_source,
    input  logic [dgr_pkg::VTX_W-1:0]   in_target,
    input  dgr_pkg::dgr_cmd_t           cmd,
    output dgr_pkg::dgr_sts_t           sts,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [2:0]                  out_status,
    output logic [dgr_pkg::VTX_W-1:0]   out_row_vertex,
    output logic [dgr_pkg::ROW_W-1:0]   out_row_bits,
    output logic                        out_last
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [dgr_pkg::ROW_W-1:0] adj_reg [DEPTH];
    logic [dgr_pkg::VTX_W-1:0] pred_mem [DEPTH];

    logic [dgr_pkg::CNT_W-1:0] vc_reg;
    logic [1:0]                op_reg;
    logic [dgr_pkg::VTX_W-1:0] src_reg;
    logic [dgr_pkg::VTX_W-1:0] tgt_reg;
    logic [dgr_pkg::VTX_W-1:0] cur_reg;
    logic [dgr_pkg::VTX_W-1:0] pv_reg;
    logic [dgr_pkg::ROW_W-1:0] visited_reg;

    logic                      out_valid_reg;
    logic [2:0]                out_status_reg;
    logic [dgr_pkg::VTX_W-1:0] out_rv_reg;
    logic [dgr_pkg::ROW_W-1:0] out_bits_reg;
    logic                      out_last_reg;

    logic [dgr_pkg::CNT_W-1:0] n_eff;
    logic [dgr_pkg::ROW_W-1:0] valid_mask;
    logic [IDX_W-1:0]          rd_idx;
    logic [dgr_pkg::ROW_W-1:0] row_rd;
    logic [dgr_pkg::ROW_W-1:0] row_masked;
    logic [dgr_pkg::ROW_W-1:0] cand;
    logic [dgr_pkg::VTX_W-1:0] nxt;

    always_comb
    begin
        if (vc_reg == '0)
        begin
            n_eff = dgr_pkg::CNT_W'(1);
        end
        else if (vc_reg > dgr_pkg::CNT_W'(DEPTH))
        begin
            n_eff = dgr_pkg::CNT_W'(DEPTH);
        end
        else
        begin
            n_eff = vc_reg;
        end
    end

    assign valid_mask = dgr_pkg::ROW_W'(({1'b0, dgr_pkg::ROW_W'(0)} | 17'd1) << n_eff)
                        - dgr_pkg::ROW_W'(1);
    assign rd_idx     = cmd.emit_row ? pv_reg[IDX_W-1:0] : cur_reg[IDX_W-1:0];
    assign row_rd     = adj_reg[rd_idx];
    assign row_masked = row_rd & valid_mask;
    assign cand       = row_masked & ~visited_reg & ~(dgr_pkg::ROW_W'(1) << cur_reg);
    assign nxt        = dgr_pkg::lowest_set(cand);

    assign sts.op         = op_reg;
    assign sts.bad_vertex = ({1'b0, src_reg} >= n_eff) || ({1'b0, tgt_reg} >= n_eff);
    assign sts.at_target  = cur_reg == tgt_reg;
    assign sts.has_cand   = cand != '0;
    assign sts.at_source  = cur_reg == src_reg;
    assign sts.row_last   = ({1'b0, pv_reg} + dgr_pkg::CNT_W'(1)) == n_eff;
    assign sts.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= dgr_pkg::CNT_W'(16);
        end
        else if (cfg_wr_en)
        begin
            vc_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                adj_reg[i] <= '0;
            end
        end
        else if (cmd.add_edge)
        begin
            adj_reg[src_reg[IDX_W-1:0]] <= adj_reg[src_reg[IDX_W-1:0]]
                                           | (dgr_pkg::ROW_W'(1) << tgt_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search_init)
        begin
            pred_mem[src_reg[IDX_W-1:0]] <= src_reg;
        end
        else if (cmd.step_fwd)
        begin
            pred_mem[nxt[IDX_W-1:0]] <= cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg     <= '0;
            visited_reg <= '0;
            pv_reg      <= '0;
        end
        else
        begin
            if (cmd.search_init)
            begin
                cur_reg     <= src_reg;
                visited_reg <= dgr_pkg::ROW_W'(1) << src_reg;
            end
            else if (cmd.step_fwd)
            begin
                cur_reg     <= nxt;
                visited_reg <= visited_reg | (dgr_pkg::ROW_W'(1) << nxt);
            end
            else if (cmd.step_back)
            begin
                cur_reg <= pred_mem[cur_reg[IDX_W-1:0]];
            end
            if (cmd.print_init)
            begin
                pv_reg <= '0;
            end
            else if (cmd.print_next)
            begin
                pv_reg <= pv_reg + dgr_pkg::VTX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_op;
            src_reg <= in_source;
            tgt_reg <= in_target;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= cmd.status;
            out_rv_reg     <= cmd.emit_row ? pv_reg : '0;
            out_bits_reg   <= cmd.emit_row ? row_masked : '0;
            out_last_reg   <= cmd.emit_row ? sts.row_last : 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_row_vertex = out_rv_reg;
    assign out_row_bits   = out_bits_reg;
    assign out_last       = out_last_reg;

`ifndef SYNTHESIS
    a_fwd_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_fwd |-> !visited_reg[nxt] && ({1'b0, nxt} < dgr_pkg::CNT_W'(DEPTH)))
        else $error("search moved to a visited vertex");

    a_cur_visited: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_fwd || cmd.step_back) |-> visited_reg[cur_reg])
        else $error("search current vertex not marked visited");

    a_back_target: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_back |=> visited_reg[cur_reg])
        else $error("backtrack left the visited set");
`endif

endmodule

/* sv/directed_graph_reachability.sv */
// Directed graph reachability engine over a cleared-at-reset adjacency matrix.
// Input stream (s_axis): one command word per handshake. tuser carries the op
// (add edge, reachability query, print rows); tdata carries source and target.
// Output stream (m_axis): tuser is the status code, tdata the printed row,
// tlast marks the final word caused by a command.
// cfg_wr_en/cfg_wr_data set the vertex count; write it only while idle.
// Add edge or an invalid command goes from decode to the reply state, which
// loads the status word into the output register. A query runs depth-first
// steps, at most about 2 per vertex in use; each step reads one adjacency
// row and runs it through a priority encoder.
// Print gives one row per cycle while the output register is free, one row per vertex in use.
// One command is in flight at a time; the next is taken once the last word
// of the current one is loaded into the output register.
// A stalled receiver holds the output word and pauses the print or reply.
// Reset clears the matrix and sets the vertex count to 16 at once.
module directed_graph_reachability #(
    parameter int MAX_VERTICES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // source_vertex, target_vertex
    input  logic [1:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // row_vertex, row_bits, zero fill
    output logic [2:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast
);

    localparam int DEPTH = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;

    dgr_pkg::dgr_cmd_t         cmd;
    dgr_pkg::dgr_sts_t         sts;
    logic [dgr_pkg::VTX_W-1:0] row_vertex;
    logic [dgr_pkg::ROW_W-1:0] row_bits;

    dgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dgr_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_op          (s_axis_tuser),
        .in_source      (s_axis_tdata[3:0]),
        .in_target      (s_axis_tdata[7:4]),
        .cmd            (cmd),
        .sts            (sts),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_status     (m_axis_tuser),
        .out_row_vertex (row_vertex),
        .out_row_bits   (row_bits),
        .out_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, row_bits, row_vertex};

endmodule

/* test/tb_top.sv */
module tb_top;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [2:0]                status;
        logic [dgr_pkg::VTX_W-1:0] row_vertex;
        logic [dgr_pkg::ROW_W-1:0] row_bits;
        logic                      last;
    } graph_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [4:0]  cfg_wr_data = 5'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // source_vertex, target_vertex
    logic [1:0]  s_axis_tuser = 2'd0;   // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // row_vertex, row_bits, zero fill
    logic [2:0]  m_axis_tuser;          // status
    logic        m_axis_tlast;

    directed_graph_reachability dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    logic [dgr_pkg::ROW_W-1:0] adj_rows [16];
    logic [4:0]                count_reg = 5'd16;
    logic [dgr_pkg::ROW_W-1:0] dfs_visited;
    logic [dgr_pkg::VTX_W-1:0] dfs_parent [16];
    logic [dgr_pkg::VTX_W-1:0] dfs_at;

    graph_reply_t reply_queue [$];
    graph_reply_t want_reply;

    bit gaps_on = 1'b1;
    int hold_requests = 0;
    int commands_sent = 0;
    int words_checked = 0;
    int mismatches = 0;
    int cycle_count = 0;

    initial
    begin
        for (int i = 0; i < 16; i++)
        begin
            adj_rows[i] = '0;
            dfs_parent[i] = '0;
        end
        dfs_visited = '0;
        dfs_at = '0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at word %0d: %s got %0d, expected %0d",
                 words_checked, what, got, want);
        mismatches++;
    endtask

    function automatic int active_vertices();
        int n;
        n = int'(count_reg);
        if (n < 1)
            n = 1;
        if (n > 16)
            n = 16;
        return n;
    endfunction

    function automatic bit dfs_reaches(input logic [3:0] src, input logic [3:0] dst,
                                       input int n);
        logic [dgr_pkg::ROW_W-1:0] in_use;
        logic [dgr_pkg::ROW_W-1:0] cand;
        int pick;
        in_use = dgr_pkg::ROW_W'((32'd1 << n) - 1);
        dfs_visited = dgr_pkg::ROW_W'(1) << src;
        dfs_parent[src] = src;
        dfs_at = src;
        for (int hop = 0; hop < 40; hop++)
        begin
            if (dfs_at == dst)
                return 1'b1;
            cand = adj_rows[dfs_at] & in_use & ~dfs_visited
                   & ~(dgr_pkg::ROW_W'(1) << dfs_at);
            if (cand != '0)
            begin
                pick = 0;
                while (!cand[pick])
                    pick++;
                dfs_parent[pick] = dfs_at;
                dfs_visited[pick] = 1'b1;
                dfs_at = dgr_pkg::VTX_W'(pick);
            end
            else if (dfs_at == src)
                return 1'b0;
            else
                dfs_at = dfs_parent[dfs_at];
        end
        return 1'b0;
    endfunction

    function automatic void predict_command(input logic [1:0] op, input logic [3:0] src,
                                            input logic [3:0] dst);
        int n;
        graph_reply_t r;
        logic [dgr_pkg::ROW_W-1:0] in_use;
        n = active_vertices();
        in_use = dgr_pkg::ROW_W'((32'd1 << n) - 1);
        r = '0;
        r.last = 1'b1;
        r.status = dgr_pkg::ST_INVALID;
        if (op == dgr_pkg::OP_PRINT)
        begin
            for (int v = 0; v < n; v++)
            begin
                r.status = dgr_pkg::ST_ROW;
                r.row_vertex = dgr_pkg::VTX_W'(v);
                r.row_bits = adj_rows[v] & in_use;
                r.last = (v == n - 1);
                reply_queue.push_back(r);
            end
            return;
        end
        if ((op == dgr_pkg::OP_ADD || op == dgr_pkg::OP_CONN) && src < n && dst < n)
        begin
            if (op == dgr_pkg::OP_ADD)
            begin
                adj_rows[src][dst] = 1'b1;
                r.status = dgr_pkg::ST_ADDED;
            end
            else
                r.status = dfs_reaches(src, dst, n) ? dgr_pkg::ST_REACH
                                                    : dgr_pkg::ST_NOREACH;
        end
        reply_queue.push_back(r);
    endfunction

    task automatic send_command(input logic [1:0] op, input logic [3:0] src,
                                input logic [3:0] dst);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {dst, src};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_command(op, src, dst);
        commands_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (reply_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [4:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        count_reg = value;
    endtask

    task automatic send_random_command();
        int n;
        int pick;
        logic [1:0] op;
        logic [3:0] src;
        logic [3:0] dst;
        n = active_vertices();
        pick = $urandom_range(0, 99);
        src = 4'($urandom_range(0, n - 1));
        dst = 4'($urandom_range(0, n - 1));
        if (pick < 45)
            op = dgr_pkg::OP_ADD;
        else if (pick < 85)
            op = dgr_pkg::OP_CONN;
        else if (pick < 91)
            op = dgr_pkg::OP_PRINT;
        else
        begin
            if (pick < 96)
                op = $urandom_range(0, 1) ? dgr_pkg::OP_ADD : dgr_pkg::OP_CONN;
            else
                op = OP_UNUSED;
            src = 4'($urandom);
            dst = 4'($urandom);
        end
        send_command(op, src, dst);
    endtask

    // drop ready in random bursts, or for a long stretch on request
    initial
    begin : reply_sink
        int stall_left;
        int hold_left;
        int holds_served;
        stall_left = 0;
        hold_left = 0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (reply_queue.size() == 0)
                report_mismatch("word with nothing pending, status", int'(m_axis_tuser), 0);
            else
            begin
                want_reply = reply_queue.pop_front();
                if (m_axis_tuser !== want_reply.status)
                    report_mismatch("status", int'(m_axis_tuser),
                                    int'(want_reply.status));
                if (m_axis_tdata[3:0] !== want_reply.row_vertex)
                    report_mismatch("row_vertex", int'(m_axis_tdata[3:0]),
                                    int'(want_reply.row_vertex));
                if (m_axis_tdata[19:4] !== want_reply.row_bits)
                    report_mismatch("row_bits", int'(m_axis_tdata[19:4]),
                                    int'(want_reply.row_bits));
                if (m_axis_tlast !== want_reply.last)
                    report_mismatch("last", int'(m_axis_tlast), int'(want_reply.last));
            end
            words_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies pending",
                     cycle_count, reply_queue.size());
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic test_reset_and_corners();
        send_command(dgr_pkg::OP_PRINT, 4'd0, 4'd0);
        send_command(dgr_pkg::OP_ADD, 4'd0, 4'd15);
        send_command(dgr_pkg::OP_ADD, 4'd15, 4'd15);
        send_command(dgr_pkg::OP_ADD, 4'd15, 4'd7);
        send_command(dgr_pkg::OP_CONN, 4'd0, 4'd7);
        send_command(dgr_pkg::OP_CONN, 4'd15, 4'd3);
        send_command(dgr_pkg::OP_CONN, 4'd7, 4'd7);
        send_command(dgr_pkg::OP_CONN, 4'd7, 4'd0);
        send_command(OP_UNUSED, 4'd15, 4'd15);
        send_command(OP_UNUSED, 4'd0, 4'd0);
        send_command(dgr_pkg::OP_PRINT, 4'd15, 4'd15);
    endtask

    task automatic test_count_extremes();
        write_vertex_count(5'd0);
        send_command(dgr_pkg::OP_CONN, 4'd0, 4'd0);
        send_command(dgr_pkg::OP_ADD, 4'd0, 4'd1);
        send_command(dgr_pkg::OP_PRINT, 4'd0, 4'd0);
        send_command(dgr_pkg::OP_CONN, 4'd1, 4'd0);
        write_vertex_count(5'd31);
        send_command(dgr_pkg::OP_PRINT, 4'd0, 4'd0);
        write_vertex_count(5'd1);
        send_command(dgr_pkg::OP_ADD, 4'd0, 4'd0);
        send_command(dgr_pkg::OP_PRINT, 4'd0, 4'd0);
    endtask

    task automatic test_stale_edges();
        write_vertex_count(5'd8);
        send_command(dgr_pkg::OP_PRINT, 4'd0, 4'd0);
        send_command(dgr_pkg::OP_CONN, 4'd0, 4'd7);
        send_command(dgr_pkg::OP_ADD, 4'd3, 4'd8);
        send_command(dgr_pkg::OP_CONN, 4'd8, 4'd0);
        write_vertex_count(5'd16);
        send_command(dgr_pkg::OP_CONN, 4'd0, 4'd7);
    endtask

    task automatic test_random_phase(input logic [4:0] count, input int items);
        write_vertex_count(count);
        repeat (items) send_random_command();
    endtask

    task automatic test_receiver_hold();
        wait_drained();
        hold_requests++;
        repeat (25) send_random_command();
    endtask

    task automatic test_sender_pause();
        repeat (12) send_random_command();
        wait_drained();
        repeat (12) send_random_command();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_and_corners();
        test_count_extremes();
        test_stale_edges();
        test_random_phase(5'd5, 40);
        test_random_phase(5'd10, 45);
        test_random_phase(5'd2, 15);
        test_receiver_hold();
        test_random_phase(5'd16, 50);
        test_sender_pause();
        gaps_on = 1'b0;
        test_random_phase(5'd31, 45);
        wait_drained();
        repeat (40) @(posedge clk);
        if (reply_queue.size() != 0)
            report_mismatch("replies never sent", 0, reply_queue.size());
        $display("ran %0d commands (add, query, print, bad vertex, unused op), %0d words",
                 commands_sent, words_checked);
        $display("vertex counts 0 to 31, stale edges, self loops, long stall, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
